FILE: rtl/core/rge_pkg.sv
// Shared types and constants of the rotated 2D Gaussian evaluator.
`timescale 1ns / 1ps
`default_nettype none

package rge_pkg;

    localparam int unsigned COORD_W   = 24;
    localparam int unsigned DIFF_W    = 25;
    localparam int unsigned COEF_W    = 32;
    localparam int unsigned PROD_W    = 57;
    localparam int unsigned SUM_W     = 58;
    localparam int unsigned NUM_W     = 56;
    localparam int unsigned SPREAD_W  = 24;
    localparam int unsigned QUO_W     = 31;
    localparam int unsigned DIV_LAT   = 31;
    localparam int unsigned EXP_TERMS = 12;
    localparam int unsigned PIPE_LAT  = 4 + DIV_LAT + 4 + 2 * EXP_TERMS + 3;

    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [15:0] QUARTER_TURN = 16'd23040;
    localparam logic [15:0] HALF_TURN    = 16'd46080;
    // One degree in radians, Q30; the fraction of the Q8.8 angle is shifted out after the multiply.
    localparam logic [24:0] DEG_TO_RAD   = 25'd18740330;
    localparam logic [30:0] LOG2E_Q30    = 31'd1549082005;
    localparam logic [29:0] LN2_Q30      = 30'd744261118;

    localparam logic [2:0] REG_AMPLITUDE = 3'd0;
    localparam logic [2:0] REG_CENTRE_X  = 3'd1;
    localparam logic [2:0] REG_CENTRE_Y  = 3'd2;
    localparam logic [2:0] REG_SPREAD_X  = 3'd3;
    localparam logic [2:0] REG_SPREAD_Y  = 3'd4;
    localparam logic [2:0] REG_ANGLE     = 3'd5;

    // Series divisors: sine terms first, then cosine terms. Each division of a
    // 32-bit value is a multiply by the rounded-up reciprocal and a shift.
    localparam int unsigned TRIG_DIVS = 11;
    localparam logic [3:0]  SIN_LAST  = 4'd5;
    localparam logic [3:0]  COS_LAST  = 4'd10;

    localparam logic [32:0] TRIG_RCP [TRIG_DIVS] = '{
        33'(((64'd1 << 40) + 64'd155) / 64'd156),
        33'(((64'd1 << 39) + 64'd109) / 64'd110),
        33'(((64'd1 << 39) + 64'd71) / 64'd72),
        33'(((64'd1 << 38) + 64'd41) / 64'd42),
        33'(((64'd1 << 37) + 64'd19) / 64'd20),
        33'(((64'd1 << 35) + 64'd5) / 64'd6),
        33'(((64'd1 << 40) + 64'd131) / 64'd132),
        33'(((64'd1 << 39) + 64'd89) / 64'd90),
        33'(((64'd1 << 38) + 64'd55) / 64'd56),
        33'(((64'd1 << 37) + 64'd29) / 64'd30),
        33'(((64'd1 << 36) + 64'd11) / 64'd12)
    };

    localparam logic [5:0] TRIG_SHIFT [TRIG_DIVS] = '{
        6'd40, 6'd39, 6'd39, 6'd38, 6'd37, 6'd35,
        6'd40, 6'd39, 6'd38, 6'd37, 6'd36
    };

    // Exponential series, divisors 12 down to 1, for 30-bit dividends.
    localparam logic [30:0] EXP_RCP [EXP_TERMS] = '{
        31'(((64'd1 << 34) + 64'd11) / 64'd12),
        31'(((64'd1 << 34) + 64'd10) / 64'd11),
        31'(((64'd1 << 34) + 64'd9) / 64'd10),
        31'(((64'd1 << 34) + 64'd8) / 64'd9),
        31'(((64'd1 << 33) + 64'd7) / 64'd8),
        31'(((64'd1 << 33) + 64'd6) / 64'd7),
        31'(((64'd1 << 33) + 64'd5) / 64'd6),
        31'(((64'd1 << 33) + 64'd4) / 64'd5),
        31'(((64'd1 << 32) + 64'd3) / 64'd4),
        31'(((64'd1 << 32) + 64'd2) / 64'd3),
        31'(((64'd1 << 31) + 64'd1) / 64'd2),
        31'((64'd1 << 30) / 64'd1)
    };

    localparam logic [5:0] EXP_SHIFT [EXP_TERMS] = '{
        6'd34, 6'd34, 6'd34, 6'd34, 6'd33, 6'd33,
        6'd33, 6'd33, 6'd32, 6'd32, 6'd31, 6'd30
    };

    typedef enum logic [2:0] {
        TRIG_IDLE,
        TRIG_ARG,
        TRIG_SQR,
        TRIG_MUL,
        TRIG_DIV,
        TRIG_SIN,
        TRIG_COS,
        TRIG_FIN
    } trig_state_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] sn;
        logic signed [COEF_W-1:0] cs;
    } trig_coef_t;

    typedef struct packed {
        logic [29:0] y;
        logic [4:0]  n;
        logic        unf;
    } exp_side_t;

endpackage

`default_nettype wire

FILE: rtl/core/rotated_gaussian_2d_evaluator.sv
// Top level of the rotated elliptical 2D Gaussian evaluator.
`timescale 1ns / 1ps
`default_nettype none

// Evaluates amplitude * exp(-z) for one pixel per clock, where z is the rotated
// elliptical quadratic form around the configured centre. The pipeline takes a
// new transaction every cycle while the output side keeps up and no angle update
// is in progress; a stall on the output freezes the whole pipeline. Writing angle_deg
// starts a sine and cosine sequence on one shared multiplier, and in_ready stays low
// until it ends. A zero spread gives bad_spread = 1 and value 0. Registers sit at
// byte addresses 0x00 to 0x14 in the order amplitude, centre_x, centre_y, spread_x,
// spread_y, angle_deg.
module rotated_gaussian_2d_evaluator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [23:0] pixel_x,
    input  wire logic signed [23:0] pixel_y,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      value,
    output logic                    bad_spread
);

    localparam int unsigned LAT = rge_pkg::PIPE_LAT;
    localparam int unsigned NT  = rge_pkg::EXP_TERMS;

    // Configuration registers.
    logic signed [31:0] amplitude_reg, amplitude_next;
    logic signed [23:0] centre_x_reg, centre_x_next;
    logic signed [23:0] centre_y_reg, centre_y_next;
    logic [23:0]        spread_x_reg, spread_x_next;
    logic [23:0]        spread_y_reg, spread_y_next;
    logic [15:0]        angle_reg, angle_next;

    logic       cfg_wr;
    logic [2:0] cfg_idx;
    logic       angle_wr;

    logic                trig_busy;
    rge_pkg::trig_coef_t coef;

    logic           adv;
    logic           take;
    logic [LAT-1:0] vld_reg, vld_next;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[4:2];
    assign angle_wr = cfg_wr && (cfg_idx == rge_pkg::REG_ANGLE);

    always_comb
    begin
        amplitude_next = amplitude_reg;
        centre_x_next  = centre_x_reg;
        centre_y_next  = centre_y_reg;
        spread_x_next  = spread_x_reg;
        spread_y_next  = spread_y_reg;
        angle_next     = angle_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                rge_pkg::REG_AMPLITUDE: amplitude_next = pwdata;
                rge_pkg::REG_CENTRE_X:  centre_x_next  = pwdata[23:0];
                rge_pkg::REG_CENTRE_Y:  centre_y_next  = pwdata[23:0];
                rge_pkg::REG_SPREAD_X:  spread_x_next  = pwdata[23:0];
                rge_pkg::REG_SPREAD_Y:  spread_y_next  = pwdata[23:0];
                rge_pkg::REG_ANGLE:     angle_next     = pwdata[15:0];
                default:                angle_next     = angle_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            rge_pkg::REG_AMPLITUDE: prdata = amplitude_reg;
            rge_pkg::REG_CENTRE_X:  prdata = {8'd0, centre_x_reg};
            rge_pkg::REG_CENTRE_Y:  prdata = {8'd0, centre_y_reg};
            rge_pkg::REG_SPREAD_X:  prdata = {8'd0, spread_x_reg};
            rge_pkg::REG_SPREAD_Y:  prdata = {8'd0, spread_y_reg};
            rge_pkg::REG_ANGLE:     prdata = {16'd0, angle_reg};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg <= 32'sd65536;
            centre_x_reg  <= '0;
            centre_y_reg  <= '0;
            spread_x_reg  <= 24'd256;
            spread_y_reg  <= 24'd256;
            angle_reg     <= '0;
        end
        else
        begin
            amplitude_reg <= amplitude_next;
            centre_x_reg  <= centre_x_next;
            centre_y_reg  <= centre_y_next;
            spread_x_reg  <= spread_x_next;
            spread_y_reg  <= spread_y_next;
            angle_reg     <= angle_next;
        end
    end

    rge_trig u_trig (
        .clk   (clk),
        .rst_n (rst_n),
        .start (angle_wr),
        .angle (angle_next),
        .busy  (trig_busy),
        .coef  (coef)
    );

    // Flow control: every stage moves together, the last stage is the output register.
    assign adv      = !vld_reg[LAT-1] || out_ready;
    assign in_ready = adv && !trig_busy;
    assign take     = in_valid && in_ready;
    assign vld_next = adv ? {vld_reg[LAT-2:0], take} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Offsets from the centre.
    logic signed [rge_pkg::DIFF_W-1:0] dx_reg, dx_next, dy_reg, dy_next;

    assign dx_next = rge_pkg::DIFF_W'(pixel_x) - rge_pkg::DIFF_W'(centre_x_reg);
    assign dy_next = rge_pkg::DIFF_W'(pixel_y) - rge_pkg::DIFF_W'(centre_y_reg);

    // Rotation products.
    logic signed [rge_pkg::PROD_W-1:0] pxc_reg, pxc_next, pys_reg, pys_next;
    logic signed [rge_pkg::PROD_W-1:0] pyc_reg, pyc_next, pxs_reg, pxs_next;

    assign pxc_next = rge_pkg::PROD_W'(dx_reg) * rge_pkg::PROD_W'(coef.cs);
    assign pys_next = rge_pkg::PROD_W'(dy_reg) * rge_pkg::PROD_W'(coef.sn);
    assign pyc_next = rge_pkg::PROD_W'(dy_reg) * rge_pkg::PROD_W'(coef.cs);
    assign pxs_next = rge_pkg::PROD_W'(dx_reg) * rge_pkg::PROD_W'(coef.sn);

    logic signed [rge_pkg::SUM_W-1:0] nu_reg, nu_next, nv_reg, nv_next;

    assign nu_next = rge_pkg::SUM_W'(pxc_reg) + rge_pkg::SUM_W'(pys_reg);
    assign nv_next = rge_pkg::SUM_W'(pyc_reg) - rge_pkg::SUM_W'(pxs_reg);

    logic [rge_pkg::SUM_W-1:0] nu_mag, nv_mag;
    logic [rge_pkg::NUM_W-1:0] num_u_reg, num_u_next, num_v_reg, num_v_next;

    assign nu_mag     = nu_reg[rge_pkg::SUM_W-1] ? rge_pkg::SUM_W'(-nu_reg) : nu_reg;
    assign nv_mag     = nv_reg[rge_pkg::SUM_W-1] ? rge_pkg::SUM_W'(-nv_reg) : nv_reg;
    assign num_u_next = nu_mag[rge_pkg::SUM_W-1:2];
    assign num_v_next = nv_mag[rge_pkg::SUM_W-1:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            pxc_reg   <= pxc_next;
            pys_reg   <= pys_next;
            pyc_reg   <= pyc_next;
            pxs_reg   <= pxs_next;
            nu_reg    <= nu_next;
            nv_reg    <= nv_next;
            num_u_reg <= num_u_next;
            num_v_reg <= num_v_next;
        end
    end

    logic [rge_pkg::QUO_W-1:0] quo_u, quo_v;
    logic                      ovf_u, ovf_v;

    rge_div u_div_u (
        .clk (clk),
        .en  (adv),
        .num (num_u_reg),
        .den (spread_x_reg),
        .quo (quo_u),
        .ovf (ovf_u)
    );

    rge_div u_div_v (
        .clk (clk),
        .en  (adv),
        .num (num_v_reg),
        .den (spread_y_reg),
        .quo (quo_v),
        .ovf (ovf_v)
    );

    // Squares, the quadratic form and the split into a power of two and a residue.
    logic [61:0] uu_reg, uu_next, vv_reg, vv_next;
    logic        unf_sq_reg, unf_sq_next;
    logic [34:0] z_sum;
    logic [32:0] z_reg, z_next;
    logic        unf_z_reg, unf_z_next;
    logic [63:0] w_full;
    logic [33:0] w_reg, w_next;
    logic        unf_w_reg;
    logic [57:0] y_full;
    rge_pkg::exp_side_t side_y_reg, side_y_next;

    assign uu_next     = 62'(quo_u) * 62'(quo_u);
    assign vv_next     = 62'(quo_v) * 62'(quo_v);
    assign unf_sq_next = ovf_u || ovf_v;

    assign z_sum      = 35'(uu_reg[61:28]) + 35'(vv_reg[61:28]);
    assign z_next     = z_sum[33:1];
    assign unf_z_next = unf_sq_reg || z_sum[34];

    assign w_full = 64'(z_reg) * 64'(rge_pkg::LOG2E_Q30);
    assign w_next = w_full[63:30];

    assign y_full          = 58'(w_reg[27:0]) * 58'(rge_pkg::LN2_Q30);
    assign side_y_next.y   = y_full[57:28];
    assign side_y_next.n   = w_reg[32:28];
    assign side_y_next.unf = unf_w_reg || w_reg[33];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            uu_reg     <= uu_next;
            vv_reg     <= vv_next;
            unf_sq_reg <= unf_sq_next;
            z_reg      <= z_next;
            unf_z_reg  <= unf_z_next;
            w_reg      <= w_next;
            unf_w_reg  <= unf_z_reg;
            side_y_reg <= side_y_next;
        end
    end

    // exp(-y) by a Horner series, two stages per term.
    logic [29:0]        ep_reg [NT];
    logic [29:0]        ep_next [NT];
    logic [30:0]        et_reg [NT];
    logic [30:0]        et_next [NT];
    rge_pkg::exp_side_t sa_reg [NT];
    rge_pkg::exp_side_t sb_reg [NT];

    for (genvar j = 0; j < NT; j++)
    begin : g_term
        rge_pkg::exp_side_t side_in;
        logic [30:0]        t_in;
        logic [60:0]        yt;
        logic [60:0]        pm;
        logic [60:0]        q;

        if (j == 0)
        begin : g_first
            assign side_in = side_y_reg;
            assign t_in    = rge_pkg::Q30_ONE;
        end
        else
        begin : g_rest
            assign side_in = sb_reg[j-1];
            assign t_in    = et_reg[j-1];
        end

        assign yt         = 61'(side_in.y) * 61'(t_in);
        assign ep_next[j] = yt[59:30];
        assign pm         = 61'(ep_reg[j]) * 61'(rge_pkg::EXP_RCP[j]);
        assign q          = pm >> rge_pkg::EXP_SHIFT[j];
        assign et_next[j] = rge_pkg::Q30_ONE - q[30:0];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ep_reg[j] <= ep_next[j];
                sa_reg[j] <= side_in;
                et_reg[j] <= et_next[j];
                sb_reg[j] <= sa_reg[j];
            end
        end
    end

    // Amplitude scaling, rounding half away from zero.
    logic [31:0] amp_mag;
    logic [62:0] ap_reg, ap_next;
    logic [4:0]  n_ap_reg;
    logic        unf_ap_reg;
    logic [63:0] rnd;
    logic [63:0] mag_full;
    logic [31:0] mag_reg, mag_next;
    logic        unf_mag_reg;
    logic        zero_out;
    logic signed [31:0] value_reg, value_next;
    logic        bad_reg, bad_next;

    assign amp_mag  = amplitude_reg[31] ? 32'd0 - amplitude_reg : amplitude_reg;
    assign ap_next  = 63'(amp_mag) * 63'(et_reg[NT-1]);
    assign rnd      = 64'(ap_reg) + (64'd1 << (6'd29 + 6'(n_ap_reg)));
    assign mag_full = rnd >> (6'd30 + 6'(n_ap_reg));
    assign mag_next = mag_full[31:0];

    assign bad_next   = (spread_x_reg == '0) || (spread_y_reg == '0);
    assign zero_out   = bad_next || unf_mag_reg;
    assign value_next = zero_out ? 32'sd0
                      : (amplitude_reg[31] ? 32'd0 - mag_reg : mag_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ap_reg      <= ap_next;
            n_ap_reg    <= sb_reg[NT-1].n;
            unf_ap_reg  <= sb_reg[NT-1].unf;
            mag_reg     <= mag_next;
            unf_mag_reg <= unf_ap_reg;
            value_reg   <= value_next;
            bad_reg     <= bad_next;
        end
    end

    assign out_valid  = vld_reg[LAT-1];
    assign value      = value_reg;
    assign bad_spread = bad_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rge_trig.sv
// Sequencer that turns the rotation angle into sine and cosine in Q30.
`timescale 1ns / 1ps
`default_nettype none

module rge_trig (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [15:0]        angle,
    output logic                    busy,
    output rge_pkg::trig_coef_t     coef
);

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    rge_pkg::trig_state_t state_reg, state_next;
    logic [3:0]  idx_reg, idx_next;
    logic [30:0] x_reg, x_next;
    logic [31:0] x2_reg, x2_next;
    logic [30:0] t_reg, t_next;
    logic [31:0] p_reg, p_next;
    logic [30:0] s_reg, s_next;
    logic [30:0] c_reg, c_next;
    rge_pkg::trig_coef_t coef_reg, coef_next;

    logic [1:0]  quad;
    logic [14:0] resid;
    logic [32:0] mul_a;
    logic [32:0] mul_b;
    logic [65:0] prod;
    logic [65:0] quot;
    logic [30:0] half;

    always_comb
    begin
        if (angle >= rge_pkg::HALF_TURN)
        begin
            quad  = QUAD_III;
            resid = 15'(angle - rge_pkg::HALF_TURN);
        end
        else if (angle >= rge_pkg::QUARTER_TURN)
        begin
            quad  = QUAD_II;
            resid = 15'(angle - rge_pkg::QUARTER_TURN);
        end
        else
        begin
            quad  = QUAD_I;
            resid = angle[14:0];
        end
    end

    // One shared multiplier; its operands follow the step in progress.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            rge_pkg::TRIG_ARG:
            begin
                mul_a = 33'(resid);
                mul_b = 33'(rge_pkg::DEG_TO_RAD);
            end
            rge_pkg::TRIG_SQR:
            begin
                mul_a = 33'(x_reg);
                mul_b = 33'(x_reg);
            end
            rge_pkg::TRIG_MUL, rge_pkg::TRIG_COS:
            begin
                mul_a = 33'(x2_reg);
                mul_b = 33'(t_reg);
            end
            rge_pkg::TRIG_DIV:
            begin
                mul_a = 33'(p_reg);
                mul_b = rge_pkg::TRIG_RCP[idx_reg];
            end
            rge_pkg::TRIG_SIN:
            begin
                mul_a = 33'(x_reg);
                mul_b = 33'(t_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 66'(mul_a) * 66'(mul_b);
    assign quot = prod >> rge_pkg::TRIG_SHIFT[idx_reg];
    assign half = prod[61:31];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        t_next     = t_reg;
        p_next     = p_reg;
        s_next     = s_reg;
        c_next     = c_reg;
        coef_next  = coef_reg;
        case (state_reg)
            rge_pkg::TRIG_IDLE:
            begin
                state_next = rge_pkg::TRIG_IDLE;
            end
            rge_pkg::TRIG_ARG:
            begin
                x_next     = prod[38:8];
                state_next = rge_pkg::TRIG_SQR;
            end
            rge_pkg::TRIG_SQR:
            begin
                x2_next    = prod[61:30];
                state_next = rge_pkg::TRIG_MUL;
            end
            rge_pkg::TRIG_MUL:
            begin
                p_next     = prod[61:30];
                state_next = rge_pkg::TRIG_DIV;
            end
            rge_pkg::TRIG_DIV:
            begin
                t_next = rge_pkg::Q30_ONE - quot[30:0];
                if (idx_reg != rge_pkg::COS_LAST)
                begin
                    idx_next = idx_reg + 4'd1;
                end
                if (idx_reg == rge_pkg::SIN_LAST)
                begin
                    state_next = rge_pkg::TRIG_SIN;
                end
                else if (idx_reg == rge_pkg::COS_LAST)
                begin
                    state_next = rge_pkg::TRIG_COS;
                end
                else
                begin
                    state_next = rge_pkg::TRIG_MUL;
                end
            end
            rge_pkg::TRIG_SIN:
            begin
                s_next     = prod[60:30];
                t_next     = rge_pkg::Q30_ONE;
                state_next = rge_pkg::TRIG_MUL;
            end
            rge_pkg::TRIG_COS:
            begin
                // Near a right angle the truncated series dips below zero; clamp it.
                c_next     = (half > rge_pkg::Q30_ONE) ? 31'd0 : rge_pkg::Q30_ONE - half;
                state_next = rge_pkg::TRIG_FIN;
            end
            rge_pkg::TRIG_FIN:
            begin
                case (quad)
                    QUAD_I:
                    begin
                        coef_next.sn = 32'(s_reg);
                        coef_next.cs = 32'(c_reg);
                    end
                    QUAD_II:
                    begin
                        coef_next.sn = 32'(c_reg);
                        coef_next.cs = 32'd0 - 32'(s_reg);
                    end
                    QUAD_III:
                    begin
                        coef_next.sn = 32'd0 - 32'(s_reg);
                        coef_next.cs = 32'd0 - 32'(c_reg);
                    end
                    default:
                    begin
                        coef_next.sn = 32'd0 - 32'(c_reg);
                        coef_next.cs = 32'(s_reg);
                    end
                endcase
                state_next = rge_pkg::TRIG_IDLE;
            end
            default:
            begin
                state_next = rge_pkg::TRIG_IDLE;
            end
        endcase
        // A new angle restarts the sequence from the argument step.
        if (start)
        begin
            state_next = rge_pkg::TRIG_ARG;
            idx_next   = 4'd0;
            t_next     = rge_pkg::Q30_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rge_pkg::TRIG_IDLE;
            idx_reg     <= 4'd0;
            coef_reg.sn <= '0;
            coef_reg.cs <= 32'(rge_pkg::Q30_ONE);
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            coef_reg  <= coef_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        x2_reg <= x2_next;
        t_reg  <= t_next;
        p_reg  <= p_next;
        s_reg  <= s_next;
        c_reg  <= c_next;
    end

    assign busy = (state_reg != rge_pkg::TRIG_IDLE);
    assign coef = coef_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rge_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`timescale 1ns / 1ps
`default_nettype none

module rge_div (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [rge_pkg::NUM_W-1:0]       num,
    input  wire logic [rge_pkg::SPREAD_W-1:0]    den,
    output logic      [rge_pkg::QUO_W-1:0]       quo,
    output logic                                 ovf
);

    localparam int unsigned SW  = rge_pkg::SPREAD_W;
    localparam int unsigned QW  = rge_pkg::QUO_W;
    localparam int unsigned LAT = rge_pkg::DIV_LAT;

    logic [SW-1:0] rem_reg [LAT];
    logic [SW-1:0] rem_next [LAT];
    logic [QW-1:0] quo_reg [LAT];
    logic [QW-1:0] quo_next [LAT];
    logic [QW-1:0] low_reg [LAT-1];
    logic [QW-1:0] low_next [LAT-1];
    logic          ovf_reg [LAT];
    logic          ovf_next [LAT];

    for (genvar i = 0; i < LAT; i++)
    begin : g_step
        logic [SW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic          ovf_in;
        logic [SW:0]   trial;
        logic          fits;

        if (i == 0)
        begin : g_first
            // A quotient that needs more than QW bits is flagged here.
            assign rem_in = num[rge_pkg::NUM_W-2:QW];
            assign low_in = num[QW-1:0];
            assign quo_in = '0;
            assign ovf_in = (num[rge_pkg::NUM_W-1:QW] >= {1'b0, den});
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign ovf_in = ovf_reg[i-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign fits  = (trial >= {1'b0, den});

        always_comb
        begin
            rem_next[i] = fits ? SW'(trial - {1'b0, den}) : trial[SW-1:0];
            quo_next[i] = {quo_in[QW-2:0], fits};
            ovf_next[i] = ovf_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
                ovf_reg[i] <= ovf_next[i];
            end
        end

        if (i < LAT - 1)
        begin : g_low
            assign low_next[i] = {low_in[QW-2:0], 1'b0};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    low_reg[i] <= low_next[i];
                end
            end
        end
    end

    assign quo = quo_reg[LAT-1];
    assign ovf = ovf_reg[LAT-1];

endmodule

`default_nettype wire
